// File: hw/rtl/skyp_pkg.sv
// skyp_pkg: shared constants and types of the skyline rectangle placer
// no dependencies

package skyp_pkg;

    localparam int ATLAS_SIZE = 256;
    localparam int ADDR_W     = $clog2(ATLAS_SIZE);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int HEIGHT_W   = $clog2(ATLAS_SIZE + 1);
    localparam int SUM_W      = HEIGHT_W + 1;
    localparam int SIZE_W     = 9;
    localparam int POS_W      = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

endpackage

// File: hw/rtl/skyp_ram.sv
// skyp_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module skyp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/skyline_rect_placer.sv
// skyline_rect_placer: bottom-left skyline placement of rectangles in a square atlas
// depends on skyp_pkg and skyp_ram
// after reset a clearing pass zeroes every column of the skyline; no request taken meanwhile
// empty or too wide request: result passes through the finish state into the output register
// other requests: two sweeps over the height memory at one read a cycle, then the result passes through
// the finish state; after a placement the skyline is raised over rect_width columns before next request

module skyline_rect_placer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [skyp_pkg::IN_DATA_W-1:0]   s_tdata,   // rect_width, rect_height
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skyp_pkg::OUT_DATA_W-1:0]  m_tdata,   // pos_u, pos_v
    output logic [1:0]                       m_tuser    // status
);

    localparam int AW = skyp_pkg::ADDR_W;
    localparam int CW = skyp_pkg::CNT_W;
    localparam int HW = skyp_pkg::HEIGHT_W;
    localparam int SW = skyp_pkg::SUM_W;
    localparam int ZW = skyp_pkg::SIZE_W;
    localparam int PW = skyp_pkg::POS_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_UP,
        S_SCAN_DN,
        S_FINISH,
        S_RAISE
    } state_t;

    function automatic logic [HW-1:0] hmax(input logic [HW-1:0] a, input logic [HW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [ZW-1:0]         w_reg, w_next;
    logic [ZW-1:0]         h_reg, h_next;
    logic                  stg_vld_reg, stg_vld_next;
    logic [AW-1:0]         stg_addr_reg, stg_addr_next;
    logic [AW-1:0]         mod_reg, mod_next;
    logic [HW-1:0]         run_reg, run_next;
    logic [HW-1:0]         best_v_reg, best_v_next;
    logic [AW-1:0]         best_u_reg, best_u_next;
    logic [PW-1:0]         res_u_reg, res_u_next;
    logic [PW-1:0]         res_v_reg, res_v_next;
    skyp_pkg::status_t     res_st_reg, res_st_next;
    logic                  out_vld_reg, out_vld_next;
    logic [PW-1:0]         out_u_reg, out_u_next;
    logic [PW-1:0]         out_v_reg, out_v_next;
    skyp_pkg::status_t     out_st_reg, out_st_next;

    logic                  h_we;
    logic [AW-1:0]         h_waddr;
    logic [HW-1:0]         h_wdata;
    logic [AW-1:0]         h_raddr;
    logic [HW-1:0]         h_rdata;
    logic                  p_we;
    logic [HW-1:0]         p_wdata;
    logic [AW-1:0]         p_raddr;
    logic [HW-1:0]         p_rdata;

    logic [ZW-1:0]         in_w;
    logic [ZW-1:0]         in_h;
    logic                  issue;
    logic [AW-1:0]         up_addr;
    logic [AW-1:0]         dn_addr;
    logic [SW-1:0]         p_sum;
    logic [AW-1:0]         wm1;
    logic [AW-1:0]         last_addr;
    logic [HW-1:0]         pre;
    logic [HW-1:0]         suf;
    logic [HW-1:0]         win_max;
    logic                  elig;
    logic                  out_free;
    logic [HW-1:0]         raise_val;

    assign in_w      = s_tdata[ZW-1:0];
    assign in_h      = s_tdata[2*ZW-1:ZW];
    assign last_addr = AW'(skyp_pkg::ATLAS_SIZE - 1);
    assign issue     = (cnt_reg != CW'(skyp_pkg::ATLAS_SIZE));
    assign up_addr   = cnt_reg[AW-1:0];
    assign dn_addr   = last_addr - cnt_reg[AW-1:0];
    assign p_sum     = SW'(dn_addr) + SW'(w_reg) - SW'(1);
    assign wm1       = AW'(w_reg - ZW'(1));
    assign out_free  = !out_vld_reg || m_tready;
    assign raise_val = HW'(SW'(best_v_reg) + SW'(h_reg));

    assign pre     = (mod_reg == '0) ? h_rdata : hmax(run_reg, h_rdata);
    assign suf     = (stg_addr_reg == last_addr || mod_reg == wm1) ? h_rdata
                     : hmax(run_reg, h_rdata);
    assign win_max = hmax(suf, p_rdata);
    assign elig    = (SW'(stg_addr_reg) + SW'(w_reg)) <= SW'(skyp_pkg::ATLAS_SIZE);

    // memory ports
    assign h_we    = (state_reg == S_CLEAR) || (state_reg == S_RAISE);
    assign h_waddr = (state_reg == S_CLEAR) ? cnt_reg[AW-1:0] : best_u_reg + cnt_reg[AW-1:0];
    assign h_wdata = (state_reg == S_CLEAR) ? '0 : raise_val;
    assign h_raddr = (state_reg == S_SCAN_UP) ? up_addr : dn_addr;
    assign p_we    = (state_reg == S_SCAN_UP) && stg_vld_reg;
    assign p_wdata = pre;
    assign p_raddr = p_sum[AW-1:0];

    skyp_ram #(
        .WIDTH (HW),
        .DEPTH (skyp_pkg::ATLAS_SIZE)
    ) u_height_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    skyp_ram #(
        .WIDTH (HW),
        .DEPTH (skyp_pkg::ATLAS_SIZE)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (stg_addr_reg),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        stg_vld_next  = 1'b0;
        stg_addr_next = stg_addr_reg;
        mod_next      = mod_reg;
        run_next      = run_reg;
        best_v_next   = best_v_reg;
        best_u_next   = best_u_reg;
        res_u_next    = res_u_reg;
        res_v_next    = res_v_reg;
        res_st_next   = res_st_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_u_next    = out_u_reg;
        out_v_next    = out_v_reg;
        out_st_next   = out_st_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg[AW-1:0] == last_addr)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    w_next      = in_w;
                    h_next      = in_h;
                    cnt_next    = '0;
                    mod_next    = '0;
                    best_v_next = HW'(skyp_pkg::ATLAS_SIZE);
                    best_u_next = '0;
                    res_u_next  = '0;
                    res_v_next  = '0;
                    if (in_w == '0 || in_h == '0)
                    begin
                        res_st_next = skyp_pkg::ST_EMPTY;
                        state_next  = S_FINISH;
                    end
                    else if (SW'(in_w) > SW'(skyp_pkg::ATLAS_SIZE))
                    begin
                        res_st_next = skyp_pkg::ST_FULL;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN_UP;
                    end
                end
            end
            S_SCAN_UP:
            begin
                // prefix maxima within blocks of rect_width columns
                if (issue)
                begin
                    stg_vld_next  = 1'b1;
                    stg_addr_next = up_addr;
                    cnt_next      = cnt_reg + CW'(1);
                end
                if (stg_vld_reg)
                begin
                    run_next = pre;
                    if (stg_addr_reg == last_addr)
                    begin
                        cnt_next   = '0;
                        state_next = S_SCAN_DN;
                    end
                    else
                    begin
                        mod_next = (mod_reg == wm1) ? '0 : mod_reg + AW'(1);
                    end
                end
            end
            S_SCAN_DN:
            begin
                // suffix maxima, merged with prefix maxima into window maxima
                if (issue)
                begin
                    stg_vld_next  = 1'b1;
                    stg_addr_next = dn_addr;
                    cnt_next      = cnt_reg + CW'(1);
                end
                if (stg_vld_reg)
                begin
                    run_next = suf;
                    mod_next = (mod_reg == '0) ? wm1 : mod_reg - AW'(1);
                    if (elig && win_max <= best_v_reg)
                    begin
                        best_v_next = win_max;
                        best_u_next = stg_addr_reg;
                    end
                    if (stg_addr_reg == '0)
                    begin
                        state_next = S_FINISH;
                        if ((SW'(best_v_next) + SW'(h_reg)) <= SW'(skyp_pkg::ATLAS_SIZE))
                        begin
                            res_st_next = skyp_pkg::ST_PLACED;
                            res_u_next  = PW'(best_u_next);
                            res_v_next  = PW'(best_v_next);
                        end
                        else
                        begin
                            res_st_next = skyp_pkg::ST_FULL;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_u_next   = res_u_reg;
                    out_v_next   = res_v_reg;
                    out_st_next  = res_st_reg;
                    cnt_next     = '0;
                    state_next   = (res_st_reg == skyp_pkg::ST_PLACED) ? S_RAISE : S_IDLE;
                end
            end
            S_RAISE:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(w_reg) - CW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            w_reg        <= '0;
            h_reg        <= '0;
            stg_vld_reg  <= 1'b0;
            stg_addr_reg <= '0;
            mod_reg      <= '0;
            run_reg      <= '0;
            best_v_reg   <= '0;
            best_u_reg   <= '0;
            res_u_reg    <= '0;
            res_v_reg    <= '0;
            res_st_reg   <= skyp_pkg::ST_EMPTY;
            out_vld_reg  <= 1'b0;
            out_u_reg    <= '0;
            out_v_reg    <= '0;
            out_st_reg   <= skyp_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            stg_vld_reg  <= stg_vld_next;
            stg_addr_reg <= stg_addr_next;
            mod_reg      <= mod_next;
            run_reg      <= run_next;
            best_v_reg   <= best_v_next;
            best_u_reg   <= best_u_next;
            res_u_reg    <= res_u_next;
            res_v_reg    <= res_v_next;
            res_st_reg   <= res_st_next;
            out_vld_reg  <= out_vld_next;
            out_u_reg    <= out_u_next;
            out_v_reg    <= out_v_next;
            out_st_reg   <= out_st_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_v_reg, out_u_reg};
    assign m_tuser  = out_st_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken during skyline clear");

    a_placed_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free && res_st_reg == skyp_pkg::ST_PLACED)
        |-> (SW'(best_v_reg) + SW'(h_reg)) <= SW'(skyp_pkg::ATLAS_SIZE))
        else $error("placed rectangle exceeds atlas height");

    a_raise_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RAISE)
        |-> (SW'(best_u_reg) + SW'(cnt_reg)) < SW'(skyp_pkg::ATLAS_SIZE))
        else $error("skyline raise beyond last column");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_FINISH))
        else $error("result appeared outside finish step");
`endif

endmodule
